// ===== rtl/core/pcmr_pkg.sv =====
// ----------------------------------------------------------------------------
// pcmr_pkg
// shared widths, register map, reset masks and cell stage types for the
// pixel channel mask repack unit
// ----------------------------------------------------------------------------
package pcmr_pkg;

    localparam int PIX_W     = 32;
    localparam int NUM_CH    = 4;
    localparam int CFG_IDX_W = 4;

    // register map
    localparam logic [CFG_IDX_W-1:0] IDX_SRC_RED   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] IDX_SRC_GREEN = 4'd1;
    localparam logic [CFG_IDX_W-1:0] IDX_SRC_BLUE  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] IDX_SRC_ALPHA = 4'd3;
    localparam logic [CFG_IDX_W-1:0] IDX_DST_RED   = 4'd4;
    localparam logic [CFG_IDX_W-1:0] IDX_DST_GREEN = 4'd5;
    localparam logic [CFG_IDX_W-1:0] IDX_DST_BLUE  = 4'd6;
    localparam logic [CFG_IDX_W-1:0] IDX_DST_ALPHA = 4'd7;

    // channel order: red, green, blue, alpha from index 0 up
    localparam logic [NUM_CH-1:0][PIX_W-1:0] SRC_MASK_RST = {
        32'hFF000000, 32'h00FF0000, 32'h0000FF00, 32'h000000FF
    };
    localparam logic [NUM_CH-1:0][PIX_W-1:0] DST_MASK_RST = {
        32'hFF000000, 32'h00FF0000, 32'h0000FF00, 32'h000000FF
    };

    typedef struct packed {
        logic [PIX_W-1:0] pixel_in;
        logic             last_in;
    } pcmr_in_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             last_out;
    } pcmr_out_t;

    // beat moving down the gather chain
    typedef struct packed {
        logic                         valid;
        logic                         last;
        logic [PIX_W-1:0]             pixel;
        logic [NUM_CH-1:0][PIX_W-1:0] chan;
    } pcmr_gather_t;

    // beat moving down the scatter chain
    typedef struct packed {
        logic                         valid;
        logic                         last;
        logic [NUM_CH-1:0][PIX_W-1:0] chan;
        logic [PIX_W-1:0]             word;
    } pcmr_scatter_t;

endpackage

// ===== rtl/core/pcmr_gather_cell.sv =====
// ----------------------------------------------------------------------------
// pcmr_gather_cell
// one source bit position: appends the pixel's top bit to every channel
// whose source mask selects this position
// ----------------------------------------------------------------------------
module pcmr_gather_cell (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic [pcmr_pkg::NUM_CH-1:0]           mask_bit,
    input  pcmr_pkg::pcmr_gather_t                stage_in,
    output pcmr_pkg::pcmr_gather_t                stage_out
);
    import pcmr_pkg::*;

    pcmr_gather_t stage_reg;
    pcmr_gather_t stage_next;

    always_comb
    begin
        stage_next       = stage_in;
        // positions are visited from high to low, so shifting left keeps
        // the lowest selected position at bit 0
        stage_next.pixel = {stage_in.pixel[PIX_W-2:0], 1'b0};
        for (int c = 0; c < NUM_CH; c++)
        begin
            if (mask_bit[c])
            begin
                stage_next.chan[c] = {stage_in.chan[c][PIX_W-2:0],
                                      stage_in.pixel[PIX_W-1]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
        end
        else
        begin
            stage_reg <= stage_next;
        end
    end

    assign stage_out = stage_reg;

endmodule

// ===== rtl/core/pcmr_scatter_cell.sv =====
// ----------------------------------------------------------------------------
// pcmr_scatter_cell
// one destination bit position: channels whose destination mask selects it
// give up their next packed bit, ORed into the output word
// ----------------------------------------------------------------------------
module pcmr_scatter_cell (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic [pcmr_pkg::NUM_CH-1:0]           mask_bit,
    input  pcmr_pkg::pcmr_scatter_t               stage_in,
    output pcmr_pkg::pcmr_scatter_t               stage_out
);
    import pcmr_pkg::*;

    pcmr_scatter_t stage_reg;
    pcmr_scatter_t stage_next;
    logic          out_bit;

    always_comb
    begin
        stage_next = stage_in;
        out_bit    = 1'b0;
        for (int c = 0; c < NUM_CH; c++)
        begin
            if (mask_bit[c])
            begin
                out_bit            = out_bit | stage_in.chan[c][0];
                stage_next.chan[c] = {1'b0, stage_in.chan[c][PIX_W-1:1]};
            end
        end
        // positions visited low to high; after all cells the first lands at bit 0
        stage_next.word = {out_bit, stage_in.word[PIX_W-1:1]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
        end
        else
        begin
            stage_reg <= stage_next;
        end
    end

    assign stage_out = stage_reg;

endmodule

// ===== rtl/core/pixel_channel_mask_repack_unit.sv =====
// ----------------------------------------------------------------------------
// pixel_channel_mask_repack_unit
// repacks a 32-bit pixel from one bitmask channel layout into another
// ----------------------------------------------------------------------------
// usage:
//   input beat: start high with src (pixel_in, last_in) is taken at that
//   clock edge; busy stays low, so a new pixel may enter every cycle
//   result beat: done is high for exactly one cycle with result
//   (pixel_out, last_out); the receiver cannot stall and need not
//   pipeline: the accepting edge and the done cycle are separated by
//   the chain of 32 gather cells followed by 32 scatter cells, each one
//   register stage for one bit position
//   throughput: one pixel per cycle, sustained
//   config: cfg_we with cfg_index and cfg_data writes one mask register
//   (0..3 source red/green/blue/alpha, 4..7 destination); others are ignored;
//   the user must change masks only while no pixel is in flight; unenforced
//   reset: all in-flight beats are dropped, masks return to the
//   byte-per-channel layout with red in the low byte
// ----------------------------------------------------------------------------
module pixel_channel_mask_repack_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  pcmr_pkg::pcmr_in_t                src,
    output logic                              done,
    output pcmr_pkg::pcmr_out_t               result,
    input  logic                              cfg_we,
    input  logic [pcmr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pcmr_pkg::PIX_W-1:0]        cfg_data
);
    import pcmr_pkg::*;

    // mask registers, one row per channel
    logic [NUM_CH-1:0][PIX_W-1:0] src_mask_reg;
    logic [NUM_CH-1:0][PIX_W-1:0] src_mask_next;
    logic [NUM_CH-1:0][PIX_W-1:0] dst_mask_reg;
    logic [NUM_CH-1:0][PIX_W-1:0] dst_mask_next;

    // chain taps: index 0 is the chain input, index PIX_W the last cell
    pcmr_gather_t  g_stage [PIX_W+1];
    pcmr_scatter_t s_stage [PIX_W+1];

    // config write decode
    always_comb
    begin
        src_mask_next = src_mask_reg;
        dst_mask_next = dst_mask_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                IDX_SRC_RED:   src_mask_next[0] = cfg_data;
                IDX_SRC_GREEN: src_mask_next[1] = cfg_data;
                IDX_SRC_BLUE:  src_mask_next[2] = cfg_data;
                IDX_SRC_ALPHA: src_mask_next[3] = cfg_data;
                IDX_DST_RED:   dst_mask_next[0] = cfg_data;
                IDX_DST_GREEN: dst_mask_next[1] = cfg_data;
                IDX_DST_BLUE:  dst_mask_next[2] = cfg_data;
                IDX_DST_ALPHA: dst_mask_next[3] = cfg_data;
                default:       ; // unmapped index, write dropped
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_mask_reg <= SRC_MASK_RST;
            dst_mask_reg <= DST_MASK_RST;
        end
        else
        begin
            src_mask_reg <= src_mask_next;
            dst_mask_reg <= dst_mask_next;
        end
    end

    // every pixel is independent and the chain never stalls
    assign busy = 1'b0;

    // beat entering the gather chain
    always_comb
    begin
        g_stage[0].valid = start;
        g_stage[0].last  = src.last_in;
        g_stage[0].pixel = src.pixel_in;
        g_stage[0].chan  = '0;
    end

    // gather chain: cell k handles source position PIX_W-1-k
    for (genvar k = 0; k < PIX_W; k++)
    begin : g_gather
        logic [NUM_CH-1:0] mask_bit;
        for (genvar c = 0; c < NUM_CH; c++)
        begin : g_bit
            assign mask_bit[c] = src_mask_reg[c][PIX_W-1-k];
        end
        pcmr_gather_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .mask_bit  (mask_bit),
            .stage_in  (g_stage[k]),
            .stage_out (g_stage[k+1])
        );
    end

    // hand packed channel values over to the scatter chain
    always_comb
    begin
        s_stage[0].valid = g_stage[PIX_W].valid;
        s_stage[0].last  = g_stage[PIX_W].last;
        s_stage[0].chan  = g_stage[PIX_W].chan;
        s_stage[0].word  = '0;
    end

    // scatter chain: cell k handles destination position k
    for (genvar k = 0; k < PIX_W; k++)
    begin : g_scatter
        logic [NUM_CH-1:0] mask_bit;
        for (genvar c = 0; c < NUM_CH; c++)
        begin : g_bit
            assign mask_bit[c] = dst_mask_reg[c][k];
        end
        pcmr_scatter_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .mask_bit  (mask_bit),
            .stage_in  (s_stage[k]),
            .stage_out (s_stage[k+1])
        );
    end

    // last scatter cell is the output register
    assign done             = s_stage[PIX_W].valid;
    assign result.pixel_out = s_stage[PIX_W].word;
    assign result.last_out  = s_stage[PIX_W].last;

    // every accepted pixel comes out exactly after the full chain
    a_start_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##64 done)
        else $error("accepted pixel did not reach the output in time");

    // no result without a pixel accepted one chain length earlier
    a_done_has_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 64))
        else $error("result beat without a matching input beat");

    // all pixel bits are consumed by the end of the gather chain
    a_gather_drained: assert property (@(posedge clk) disable iff (!rst_n)
        g_stage[PIX_W].valid |-> (g_stage[PIX_W].pixel == '0))
        else $error("gather chain left pixel bits unconsumed");

endmodule
